>>> src/bhe_pkg.sv
`timescale 1ns / 1ps

package bhe_pkg;

  // Operation codes carried by the func field of an input word.
  typedef enum logic [1:0] {
    FUNC_COUNT      = 2'd0,
    FUNC_READ_BIN   = 2'd1,
    FUNC_CLEAR      = 2'd2,
    FUNC_READ_TOTAL = 2'd3
  } func_t;

  localparam int unsigned SAMPLE_WIDTH  = 8;
  localparam int unsigned OUT_WIDTH     = 32;
  localparam int unsigned NUM_BINS_DEF  = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Control group from the pipeline to the bin store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } store_ctl_t;

endpackage

>>> src/bhe_if.sv
`timescale 1ns / 1ps

interface bhe_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [bhe_pkg::SAMPLE_WIDTH-1:0]  sample_value;
  logic [bhe_pkg::SAMPLE_WIDTH-1:0]  bin_index;

  modport source (output valid, func, sample_value, bin_index, input ready);
  modport sink   (input valid, func, sample_value, bin_index, output ready);
endinterface

interface bhe_out_if;
  logic                           valid;
  logic                           ready;
  logic [bhe_pkg::OUT_WIDTH-1:0]  read_value;
  logic                           saturated;

  modport source (output valid, read_value, saturated, input ready);
  modport sink   (input valid, read_value, saturated, output ready);
endinterface

>>> src/byte_histogram_engine.sv
`timescale 1ns / 1ps

// Byte value histogram. Throughput is one input word per cycle, set by the
// single read-modify-write pass over the bin memory with write forwarding.
// A read word's result is loaded from stage 1 into the output register;
// while that register is full and not being taken, the read word in stage 1
// holds off all input. Reset (rst, synchronous) empties the pipeline, zeroes
// the total and clears the per-bin valid flags, so every bin reads as zero.
module byte_histogram_engine #(
  parameter int unsigned NUM_BINS    = bhe_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = bhe_pkg::COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  bhe_in_if.sink     item,
  bhe_out_if.source  result
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned SW = bhe_pkg::SAMPLE_WIDTH;
  localparam int unsigned OW = bhe_pkg::OUT_WIDTH;

  // Stage 0 is the accepting edge: the bin address is worked out and the
  // memory read is launched. Stage 1 holds the word while the read data
  // arrives, then writes the incremented count back, clears, or loads the output.
  logic              s1_valid;
  bhe_pkg::func_t    s1_func;
  logic [AW-1:0]     s1_addr;
  logic              s1_oob;

  // Record of what stage 1 did at the previous edge. The memory read that
  // launched at that same edge saw the old contents, so stage 1 forwards
  // the written count or the clear from here.
  logic                   fwd_wr;
  logic                   fwd_clr;
  logic [AW-1:0]          fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic [COUNT_WIDTH-1:0] total;
  logic                   out_valid;
  logic [OW-1:0]          out_value;
  logic                   out_sat;

  bhe_pkg::store_ctl_t    store_ctl;
  logic [AW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] bin_cur;
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic [COUNT_WIDTH-1:0] total_inc;
  logic [COUNT_WIDTH-1:0] emit_src;
  logic [63:0]            emit_ext;
  logic                   emit_over;
  logic [OW-1:0]          emit_value;
  logic                   emit_sat;

  logic item_fire;
  logic s1_has_res;
  logic s1_go;
  logic s1_load;
  logic s0_oob;

  bhe_pkg::func_t item_func;

  assign item_func = bhe_pkg::func_t'(item.func);

  // A read word in stage 1 waits only while the output register is full
  // and not being taken; count and clear words never wait.
  assign s1_has_res = (s1_func == bhe_pkg::FUNC_READ_BIN) ||
                      (s1_func == bhe_pkg::FUNC_READ_TOTAL);
  assign s1_go      = s1_valid && (!s1_has_res || !out_valid || result.ready);
  assign s1_load    = !s1_valid || s1_go;
  assign item.ready = s1_load;
  assign item_fire  = item.valid && item.ready;

  // Samples beyond the last bin are counted in the last bin; a read beyond
  // the bins returns zero without saturation.
  always_comb begin
    s0_oob  = 1'b0;
    rd_addr = '0;
    if (item_func == bhe_pkg::FUNC_COUNT) begin
      if ({1'b0, item.sample_value} >= (SW + 1)'(NUM_BINS)) begin
        rd_addr = AW'(NUM_BINS - 1);
      end else begin
        rd_addr = item.sample_value[AW-1:0];
      end
    end else begin
      rd_addr = item.bin_index[AW-1:0];
      s0_oob  = {1'b0, item.bin_index} >= (SW + 1)'(NUM_BINS);
    end
  end

  always_comb begin
    if (fwd_clr) begin
      bin_cur = '0;
    end else if (fwd_wr && (fwd_addr == s1_addr)) begin
      bin_cur = fwd_data;
    end else begin
      bin_cur = rd_data;
    end
  end

  assign bin_inc   = (&bin_cur) ? bin_cur : bin_cur + COUNT_WIDTH'(1);
  assign total_inc = (&total) ? total : total + COUNT_WIDTH'(1);

  // Counts over the output maximum clamp to it and report saturation, as does a full counter.
  assign emit_src   = (s1_func == bhe_pkg::FUNC_READ_TOTAL) ? total : bin_cur;
  assign emit_ext   = 64'(emit_src);
  assign emit_over  = |emit_ext[63:OW];
  assign emit_value = emit_over ? '1 : emit_ext[OW-1:0];
  assign emit_sat   = (&emit_src) || emit_over;

  always_comb begin
    store_ctl.rd_en = item_fire;
    store_ctl.wr_en = s1_go && (s1_func == bhe_pkg::FUNC_COUNT);
    store_ctl.clr   = s1_go && (s1_func == bhe_pkg::FUNC_CLEAR);
  end

  bhe_bin_store #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .rd_addr (rd_addr),
    .wr_addr (s1_addr),
    .wr_data (bin_inc),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_wr    <= 1'b0;
      fwd_clr   <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= item.valid;
        fwd_wr   <= store_ctl.wr_en;
        fwd_clr  <= store_ctl.clr;
      end
      if (store_ctl.wr_en) begin
        total <= total_inc;
      end else if (store_ctl.clr) begin
        total <= '0;
      end
      if (s1_go && s1_has_res) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_func <= item_func;
      s1_addr <= rd_addr;
      s1_oob  <= s0_oob;
    end
    if (s1_load) begin
      fwd_addr <= s1_addr;
      fwd_data <= bin_inc;
    end
    if (s1_go && s1_has_res) begin
      if ((s1_func == bhe_pkg::FUNC_READ_BIN) && s1_oob) begin
        out_value <= '0;
        out_sat   <= 1'b0;
      end else begin
        out_value <= emit_value;
        out_sat   <= emit_sat;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.read_value = out_value;
  assign result.saturated  = out_sat;

endmodule

>>> src/bhe_bin_store.sv
`timescale 1ns / 1ps

module bhe_bin_store #(
  parameter int unsigned NUM_BINS    = bhe_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = bhe_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bhe_pkg::store_ctl_t    ctl,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          wr_addr,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] rd_data
);

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    vld;

  // Entries that were never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

endmodule

>>> sim/hist_count_check.sv
`timescale 1ns / 1ps

// Watches both channels of the histogram engine, keeps its own copy of the
// bin and total counters, and compares every result word with the oldest
// outstanding read.
module hist_count_check #(
  parameter int unsigned NUM_BINS    = bhe_pkg::NUM_BINS_DEF,
  parameter int unsigned COUNT_WIDTH = bhe_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bhe_in_if           words_in,
  bhe_out_if          words_out,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [bhe_pkg::OUT_WIDTH-1:0] value;
    logic                          sat;
  } read_result_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [63:0]            OUT_MAX = 64'hFFFF_FFFF;

  logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
  logic [COUNT_WIDTH-1:0] total_tally;
  read_result_t           pending_reads [$];
  int unsigned            mismatches  = 0;
  int unsigned            outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // Counters over the output maximum clip to it and are flagged, as is a full counter.
  function automatic read_result_t as_result(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0]  wide;
    read_result_t r;
    wide    = 64'(c);
    r.sat   = (c == CNT_MAX) || (wide > OUT_MAX);
    r.value = (wide > OUT_MAX) ? OUT_MAX[31:0] : wide[31:0];
    return r;
  endfunction

  task automatic clear_tallies();
    for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
    total_tally = '0;
  endtask

  task automatic apply_word(input bhe_pkg::func_t f, input logic [7:0] sample,
                            input logic [7:0] idx);
    int unsigned  b;
    read_result_t r;
    case (f)
      bhe_pkg::FUNC_COUNT: begin
        // Samples past the last bin land in the last bin.
        b = (sample >= NUM_BINS) ? NUM_BINS - 1 : sample;
        bin_tally[b] = bump(bin_tally[b]);
        total_tally  = bump(total_tally);
      end
      bhe_pkg::FUNC_READ_BIN: begin
        if (idx < NUM_BINS) r = as_result(bin_tally[idx]);
        else r = '0;
        pending_reads.push_back(r);
      end
      bhe_pkg::FUNC_CLEAR: clear_tallies();
      default: pending_reads.push_back(as_result(total_tally));
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    read_result_t want;
    if (rst) begin
      clear_tallies();
      pending_reads.delete();
    end else begin
      if (words_in.valid && words_in.ready)
        apply_word(bhe_pkg::func_t'(words_in.func), words_in.sample_value,
                   words_in.bin_index);
      if (words_out.valid && words_out.ready) begin
        if (pending_reads.size() == 0) begin
          flag_mismatch($sformatf("result word %0d with no read outstanding",
                                  words_out.read_value));
        end else begin
          want = pending_reads.pop_front();
          if (words_out.read_value !== want.value)
            flag_mismatch($sformatf("read_value %0d, expected %0d",
                                    words_out.read_value, want.value));
          if (words_out.saturated !== want.sat)
            flag_mismatch($sformatf("saturated %0b, expected %0b",
                                    words_out.saturated, want.sat));
        end
      end
    end
    outstanding <= pending_reads.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Top of the histogram engine bench. It drives the input channel, stalls the
// result channel, and gives the verdict; all prediction and comparison sits
// in the checker instance beside the block.
module tb_top;

  // Total number of random words sent after the directed part.
  localparam int unsigned RANDOM_WORDS = 1700;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;

  // Byte values that get about half of the random count words, so that their bins
  // grow large and reads of them return interesting counts.
  logic [7:0] hot_values [4];

  bhe_in_if  item_ch ();
  bhe_out_if result_ch ();

  byte_histogram_engine uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  hist_count_check tally_chk (
    .clk        (clk),
    .rst        (rst),
    .words_in   (item_ch),
    .words_out  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A hang anywhere in the run ends here. The slowest correct run is far
  // below this.
  initial begin
    #20_000_000;
    $display("FAIL byte_histogram_engine");
    $finish;
  end

  // The result side stalls on a pattern of its own: long stretches of
  // constant readiness, random toggling at two densities, and hard stalls.
  // Every segment waits at least one edge after each assignment, so ready
  // gets at most one update per time step.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0: begin
          result_ch.ready <= 1'b1;
          repeat ($urandom_range(5, 60)) @(posedge clk);
        end
        1: begin
          repeat ($urandom_range(5, 60)) begin
            result_ch.ready <= ($urandom_range(0, 1) == 1);
            @(posedge clk);
          end
        end
        2: begin
          result_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        default: begin
          repeat ($urandom_range(4, 30)) begin
            result_ch.ready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Present one word and hold it until the block takes it. The task is
  // always entered right after the clock rises, and it returns right after
  // the rise at which the word was accepted, with valid still high so that a
  // following word goes out back to back.
  task automatic send_word(input bhe_pkg::func_t f, input logic [7:0] sample,
                           input logic [7:0] idx);
    item_ch.valid        <= 1'b1;
    item_ch.func         <= f;
    item_ch.sample_value <= sample;
    item_ch.bin_index    <= idx;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Drop valid for a number of cycles; the sample and index fields take junk meanwhile.
  task automatic idle_for(input int unsigned n);
    if (n == 0) return;
    item_ch.valid        <= 1'b0;
    item_ch.sample_value <= 8'($urandom_range(0, 255));
    item_ch.bin_index    <= 8'($urandom_range(0, 255));
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every outstanding read has returned. The first edge
  // lets the checker's count catch up with a read accepted just before.
  task automatic drain_reads();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic pick_hot_values();
    foreach (hot_values[i]) hot_values[i] = 8'($urandom_range(0, 255));
  endtask

  // One random word. Counts dominate so the bins fill up; reads make up a
  // good third so results are plentiful; clears are rare so counts build up
  // between them. Unused fields always carry random values.
  task automatic send_random_word();
    int unsigned    roll;
    logic [7:0]     sample;
    logic [7:0]     idx;
    bhe_pkg::func_t f;
    roll   = $urandom_range(0, 99);
    sample = ($urandom_range(0, 1) == 1) ? hot_values[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
    idx    = ($urandom_range(0, 1) == 1) ? hot_values[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
    if (roll < 56)      f = bhe_pkg::FUNC_COUNT;
    else if (roll < 86) f = bhe_pkg::FUNC_READ_BIN;
    else if (roll < 98) f = bhe_pkg::FUNC_READ_TOTAL;
    else                f = bhe_pkg::FUNC_CLEAR;
    send_word(f, sample, idx);
    if (f == bhe_pkg::FUNC_CLEAR) pick_hot_values();
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;

    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.func         <= bhe_pkg::FUNC_COUNT;
    item_ch.sample_value <= '0;
    item_ch.bin_index    <= '0;
    pick_hot_values();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A fresh store must read zero everywhere, including the
    // first and last bins and the total.
    send_word(bhe_pkg::FUNC_READ_TOTAL, 8'hFF, 8'hFF);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'h00);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'hFF);
    // Counts at the extreme byte values and on alternating bit patterns,
    // with a repeated byte back to back to exercise write forwarding.
    send_word(bhe_pkg::FUNC_COUNT, 8'h00, 8'hFF);
    send_word(bhe_pkg::FUNC_COUNT, 8'hFF, 8'h00);
    send_word(bhe_pkg::FUNC_COUNT, 8'hFF, 8'h00);
    send_word(bhe_pkg::FUNC_COUNT, 8'hAA, 8'h55);
    send_word(bhe_pkg::FUNC_COUNT, 8'h55, 8'hAA);
    // Reads right behind the counts that feed them.
    send_word(bhe_pkg::FUNC_READ_BIN, 8'hFF, 8'h00);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'hFF);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h55, 8'hAA);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'hAA, 8'h55);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'h7F);
    send_word(bhe_pkg::FUNC_READ_TOTAL, 8'h00, 8'h00);
    // A clear followed at once by reads must see zero again.
    send_word(bhe_pkg::FUNC_CLEAR, 8'hFF, 8'hFF);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'hFF);
    send_word(bhe_pkg::FUNC_READ_TOTAL, 8'h00, 8'h00);
    // Count after a clear, then a count immediately followed by its read.
    send_word(bhe_pkg::FUNC_COUNT, 8'hFF, 8'h00);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h00, 8'hFF);
    send_word(bhe_pkg::FUNC_READ_TOTAL, 8'hFF, 8'hFF);
    send_word(bhe_pkg::FUNC_COUNT, 8'h80, 8'h01);
    send_word(bhe_pkg::FUNC_READ_BIN, 8'h01, 8'h80);
    send_word(bhe_pkg::FUNC_CLEAR, 8'h00, 8'h00);

    // Random part: bursts of random length separated by random gaps, with
    // some bursts sent with no gap at all. Halfway through, the sender holds
    // off until the result side has caught up completely.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 48);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        send_random_word();
        sent++;
        if (sent == RANDOM_WORDS / 2) drain_reads();
      end
      idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end

    // Wait for the last reads, then keep clocking with no input so that any
    // stray result word shows.
    drain_reads();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS byte_histogram_engine");
    end else begin
      $display("FAIL byte_histogram_engine");
    end
    $finish;
  end

endmodule
